// File: sv/chte_pkg.sv
// Constants, result codes and the controller state type of the chained hash table engine.
package chte_pkg;

  localparam int MAX_BUCKETS   = 1024;
  localparam int POOL_NODES    = 256;
  localparam int HANDLE_BITS   = 32;
  localparam int KEY_BITS      = 24;
  localparam int BKT_AW        = 10;
  localparam int BCNT_W        = 11;
  localparam int NODE_AW       = 8;
  localparam int PTR_W         = 9;
  localparam int CNT_W         = 9;
  localparam int STAT_W        = 3;
  localparam int REQ_W         = 2;
  localparam int DIV_STEPS     = 24;
  localparam int DIVC_W        = 5;
  localparam int RESET_BUCKETS = 11;

  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(POOL_NODES);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_POOL_FULL = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_INS_RD,
    S_INS_WR,
    S_HEAD_RD,
    S_HEAD_WT,
    S_NODE_RD,
    S_NODE_CHK,
    S_REM_FREE,
    S_CP_RD,
    S_CP_WR,
    S_RH_OLD_RD,
    S_RH_OLD_WT,
    S_RH_NODE_RD,
    S_RH_NODE_WT,
    S_RH_MOD,
    S_RH_HEAD_RD,
    S_RH_HEAD_WR,
    S_DONE
  } state_t;

endpackage

// File: sv/chained_hash_table_engine_top.sv
// Separate chaining hash table with pooled nodes, bucket doubling and a serial modulo unit.
// A doubling insert first moves every old bucket head aside, then rehashes each stored entry.
// One word is processed at a time; the next is accepted the cycle after the result is registered.
// After reset or a write of initial_buckets a clearing pass over all 1024 bucket heads runs first.
module chained_hash_table_engine_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chte_pkg::BCNT_W-1:0]       initial_buckets,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [chte_pkg::REQ_W-1:0]        req_type,
  input  logic [chte_pkg::KEY_BITS-1:0]     key,
  input  logic [chte_pkg::HANDLE_BITS-1:0]  record_handle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [chte_pkg::STAT_W-1:0]       status,
  output logic [chte_pkg::HANDLE_BITS-1:0]  found_handle,
  output logic [chte_pkg::BKT_AW-1:0]       bucket,
  output logic                              resized
);
  import chte_pkg::*;

  logic [PTR_W-1:0]       heads_mem [MAX_BUCKETS];
  logic [PTR_W-1:0]       old_mem   [MAX_BUCKETS];
  logic [KEY_BITS-1:0]    keys_mem  [POOL_NODES];
  logic [HANDLE_BITS-1:0] hnd_mem   [POOL_NODES];
  logic [PTR_W-1:0]       links_mem [POOL_NODES];

  state_t state, state_next;

  logic [BKT_AW-1:0]      clr;
  logic [BCNT_W-1:0]      bucket_count;
  logic [BCNT_W-1:0]      old_bc;
  logic [PTR_W-1:0]       free_head;
  logic [CNT_W-1:0]       entry_count;
  logic [REQ_W-1:0]       req_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [BKT_AW-1:0]      bkt;
  logic [BKT_AW-1:0]      cp;
  logic [BKT_AW-1:0]      rh;
  logic [PTR_W-1:0]       cur;
  logic [PTR_W-1:0]       prev;
  logic [PTR_W-1:0]       nxt;
  logic [KEY_BITS-1:0]    div_num;
  logic [BKT_AW-1:0]      rem;
  logic [DIVC_W-1:0]      div_cnt;
  logic [STAT_W-1:0]      res_status;
  logic [HANDLE_BITS-1:0] res_found;
  logic                   res_resized;

  logic [PTR_W-1:0]       heads_rd;
  logic [PTR_W-1:0]       old_rd;
  logic [KEY_BITS-1:0]    keys_rd;
  logic [HANDLE_BITS-1:0] hnd_rd;
  logic [PTR_W-1:0]       links_rd;

  logic                   heads_we;
  logic [BKT_AW-1:0]      heads_wa;
  logic [PTR_W-1:0]       heads_wd;
  logic [BKT_AW-1:0]      heads_ra;
  logic                   old_we;
  logic [BKT_AW-1:0]      old_ra;
  logic                   node_we;
  logic                   links_we;
  logic [NODE_AW-1:0]     links_wa;
  logic [PTR_W-1:0]       links_wd;
  logic [NODE_AW-1:0]     node_ra;

  logic                   accept;
  logic                   need_grow;
  logic                   grow;
  logic                   div_last;
  logic [BCNT_W-1:0]      rem_sh;
  logic [BKT_AW-1:0]      rem_next;
  logic [BCNT_W:0]        nb_wide;
  logic [BCNT_W-1:0]      nb;
  logic [BCNT_W-1:0]      cfg_clamped;
  logic                   cp_last;
  logic                   rh_last;
  logic                   key_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign accept    = in_valid && in_ready;

  assign need_grow = ({{(13-CNT_W-2){1'b0}}, entry_count, 2'b00}
                      >= 13'(3 * {2'b00, bucket_count}));
  assign grow = (req_type == REQ_INSERT) && !free_head[NODE_AW] && need_grow
                && (bucket_count < BCNT_W'(MAX_BUCKETS));

  assign nb_wide = {bucket_count, 1'b0};
  assign nb = (nb_wide > (BCNT_W+1)'(MAX_BUCKETS)) ? BCNT_W'(MAX_BUCKETS)
                                                   : nb_wide[BCNT_W-1:0];

  assign cfg_clamped = (initial_buckets == '0) ? BCNT_W'(1)
                     : (initial_buckets > BCNT_W'(MAX_BUCKETS)) ? BCNT_W'(MAX_BUCKETS)
                     : initial_buckets;

  assign rem_sh   = {rem, div_num[KEY_BITS-1]};
  assign rem_next = (rem_sh >= bucket_count) ? BKT_AW'(rem_sh - bucket_count)
                                             : rem_sh[BKT_AW-1:0];
  assign div_last = (div_cnt == DIVC_W'(DIV_STEPS - 1));

  assign cp_last = ({1'b0, cp} == old_bc - BCNT_W'(1));
  assign rh_last = ({1'b0, rh} == old_bc - BCNT_W'(1));
  assign key_hit = (keys_rd == key_r);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == BKT_AW'(MAX_BUCKETS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = grow ? S_CP_RD : S_MOD;
      end
      S_MOD: begin
        if (div_last) begin
          case (req_r)
            REQ_INSERT: state_next = free_head[NODE_AW] ? S_DONE : S_INS_RD;
            REQ_SEARCH, REQ_REMOVE: state_next = S_HEAD_RD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_INS_RD:   state_next = S_INS_WR;
      S_INS_WR:   state_next = S_DONE;
      S_HEAD_RD:  state_next = S_HEAD_WT;
      S_HEAD_WT:  state_next = heads_rd[NODE_AW] ? S_DONE : S_NODE_RD;
      S_NODE_RD:  state_next = S_NODE_CHK;
      S_NODE_CHK: begin
        if (key_hit) state_next = (req_r == REQ_REMOVE) ? S_REM_FREE : S_DONE;
        else if (links_rd[NODE_AW]) state_next = S_DONE;
        else state_next = S_NODE_RD;
      end
      S_REM_FREE: state_next = S_DONE;
      S_CP_RD:    state_next = S_CP_WR;
      S_CP_WR:    state_next = cp_last ? S_RH_OLD_RD : S_CP_RD;
      S_RH_OLD_RD: state_next = S_RH_OLD_WT;
      S_RH_OLD_WT: begin
        if (!old_rd[NODE_AW]) state_next = S_RH_NODE_RD;
        else state_next = rh_last ? S_MOD : S_RH_OLD_RD;
      end
      S_RH_NODE_RD: state_next = S_RH_NODE_WT;
      S_RH_NODE_WT: state_next = S_RH_MOD;
      S_RH_MOD:     state_next = div_last ? S_RH_HEAD_RD : S_RH_MOD;
      S_RH_HEAD_RD: state_next = S_RH_HEAD_WR;
      S_RH_HEAD_WR: begin
        if (!nxt[NODE_AW]) state_next = S_RH_NODE_RD;
        else state_next = rh_last ? S_MOD : S_RH_OLD_RD;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
    if (cfg_valid) state_next = S_CLEAR;
  end

  always_comb begin
    heads_we = 1'b0;
    heads_wa = bkt;
    heads_wd = NIL_PTR;
    heads_ra = bkt;
    old_we   = 1'b0;
    old_ra   = rh;
    node_we  = 1'b0;
    links_we = 1'b0;
    links_wa = cur[NODE_AW-1:0];
    links_wd = free_head;
    node_ra  = cur[NODE_AW-1:0];
    case (state)
      S_CLEAR: begin
        heads_we = 1'b1;
        heads_wa = clr;
        links_we = (clr < BKT_AW'(POOL_NODES));
        links_wa = clr[NODE_AW-1:0];
        links_wd = PTR_W'({1'b0, clr} + (BKT_AW+1)'(1));
      end
      S_INS_RD: node_ra = free_head[NODE_AW-1:0];
      S_INS_WR: begin
        heads_we = 1'b1;
        heads_wd = free_head;
        node_we  = 1'b1;
        links_we = 1'b1;
        links_wa = free_head[NODE_AW-1:0];
        links_wd = heads_rd;
      end
      S_NODE_CHK: begin
        if (key_hit && (req_r == REQ_REMOVE)) begin
          if (prev[NODE_AW]) begin
            heads_we = 1'b1;
            heads_wd = links_rd;
          end else begin
            links_we = 1'b1;
            links_wa = prev[NODE_AW-1:0];
            links_wd = links_rd;
          end
        end
      end
      S_REM_FREE: links_we = 1'b1;
      S_CP_RD: heads_ra = cp;
      S_CP_WR: begin
        heads_we = 1'b1;
        heads_wa = cp;
        old_we   = 1'b1;
      end
      S_RH_HEAD_WR: begin
        heads_we = 1'b1;
        heads_wd = cur;
        links_we = 1'b1;
        links_wd = heads_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (heads_we) heads_mem[heads_wa] <= heads_wd;
    heads_rd <= heads_mem[heads_ra];
    if (old_we) old_mem[cp] <= heads_rd;
    old_rd <= old_mem[old_ra];
    if (node_we) begin
      keys_mem[free_head[NODE_AW-1:0]] <= key_r;
      hnd_mem[free_head[NODE_AW-1:0]]  <= handle_r;
    end
    keys_rd <= keys_mem[node_ra];
    hnd_rd  <= hnd_mem[node_ra];
    if (links_we) links_mem[links_wa] <= links_wd;
    links_rd <= links_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      bucket_count <= BCNT_W'(RESET_BUCKETS);
      free_head    <= '0;
      entry_count  <= '0;
      out_valid    <= 1'b0;
    end else if (cfg_valid) begin
      state        <= state_next;
      clr          <= '0;
      bucket_count <= cfg_clamped;
      free_head    <= '0;
      entry_count  <= '0;
      if (out_valid && out_ready) out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      if (state == S_CLEAR) clr <= clr + BKT_AW'(1);
      if (state == S_MOD || state == S_RH_MOD) begin
        rem     <= rem_next;
        div_num <= {div_num[KEY_BITS-2:0], 1'b0};
        div_cnt <= div_cnt + DIVC_W'(1);
        if (div_last) bkt <= rem_next;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_r       <= req_type;
            key_r       <= key;
            handle_r    <= record_handle;
            res_found   <= '0;
            res_resized <= grow;
            res_status  <= STAT_NOT_FOUND;
            div_num     <= key;
            div_cnt     <= '0;
            rem         <= '0;
            cp          <= '0;
            old_bc      <= bucket_count;
          end
        end
        S_MOD: begin
          if (div_last && req_r == REQ_INSERT && free_head[NODE_AW])
            res_status <= STAT_POOL_FULL;
        end
        S_INS_WR: begin
          free_head   <= links_rd;
          entry_count <= entry_count + CNT_W'(1);
          res_status  <= STAT_INSERTED;
        end
        S_HEAD_WT: begin
          cur  <= heads_rd;
          prev <= NIL_PTR;
        end
        S_NODE_CHK: begin
          if (key_hit) begin
            if (req_r == REQ_SEARCH) begin
              res_status <= STAT_FOUND;
              res_found  <= hnd_rd;
            end else if (req_r == REQ_REMOVE) begin
              res_status <= STAT_REMOVED;
            end
          end else begin
            prev <= cur;
            cur  <= links_rd;
          end
        end
        S_REM_FREE: begin
          free_head   <= cur;
          entry_count <= entry_count - CNT_W'(1);
        end
        S_CP_WR: begin
          cp <= cp + BKT_AW'(1);
          if (cp_last) begin
            bucket_count <= nb;
            rh           <= '0;
          end
        end
        S_RH_OLD_WT: begin
          cur <= old_rd;
          if (old_rd[NODE_AW]) rh <= rh + BKT_AW'(1);
        end
        S_RH_NODE_WT: begin
          div_num <= keys_rd;
          nxt     <= links_rd;
          div_cnt <= '0;
          rem     <= '0;
        end
        S_RH_HEAD_WR: begin
          cur <= nxt;
          if (nxt[NODE_AW]) rh <= rh + BKT_AW'(1);
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            found_handle <= res_found;
            bucket       <= bkt;
            resized      <= res_resized;
          end
        end
        default: begin
        end
      endcase
      if (state_next == S_MOD && state != S_MOD && state != S_IDLE) begin
        div_num <= key_r;
        div_cnt <= '0;
        rem     <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(POOL_NODES))
    else $error("Entry count exceeds the node pool.");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    (bucket_count != '0) && (bucket_count <= BCNT_W'(MAX_BUCKETS)))
    else $error("Bucket count out of range.");

  a_pool_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && free_head[NODE_AW]) |-> (entry_count == CNT_W'(POOL_NODES)))
    else $error("Free list empty while the pool is not full.");

  a_resized_insert: assert property (@(posedge clk) disable iff (rst)
    (out_valid && resized) |-> (status == STAT_INSERTED))
    else $error("Resize reported on a word that was not inserted.");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !cfg_valid) |=> !in_ready)
    else $error("Second word accepted while one is in progress.");

endmodule
